/* sv/assert_macros.svh */
// Assertion macros used by the decoder RTL file.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define PNM_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while in reset.
`define PNM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/pnm_pkg.sv */
// Package for the PNM binary image decoder: payload structs and codes.
// No dependencies; used by pnm_binary_image_decoder.
`default_nettype none

package pnm_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_PIX = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  // Image types
  localparam logic [1:0] IMG_P4 = 2'd0;
  localparam logic [1:0] IMG_P5 = 2'd1;
  localparam logic [1:0] IMG_P6 = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_NOT_P   = 3'd1;
  localparam logic [2:0] ERR_ASCII   = 3'd2;
  localparam logic [2:0] ERR_UNKNOWN = 3'd3;
  localparam logic [2:0] ERR_HEADER  = 3'd4;
  localparam logic [2:0] ERR_SIZE    = 3'd5;

  // Characters
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] CH_4    = 8'h34;
  localparam logic [7:0] CH_6    = 8'h36;
  localparam logic [7:0] CH_9    = 8'h39;

  // Header number accumulator saturates here
  localparam int         ACC_W   = 16;
  localparam logic [19:0] ACC_CAP = 20'd65535;
  localparam logic [15:0] MAXVAL_LIMIT = 16'd255;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_file;
  } pnm_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  image_type;
    logic [12:0] img_width;
    logic [12:0] img_height;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  gray_value;
    logic [7:0]  red_value;
    logic [7:0]  green_value;
    logic [7:0]  blue_value;
    logic [2:0]  error_code;
    logic        last;
  } pnm_out_t;

endpackage

`default_nettype wire

/* sv/pnm_binary_image_decoder.sv */
// PNM (P4/P5/P6) byte-stream decoder: header parser and pixel emitter.
// Depends on pnm_pkg and assert_macros.svh.
//
//   channel   dir  handshake            payload
//   in_       in   in_valid / in_stall   pnm_pkg::pnm_in_t  (data_byte, new_file)
//   out_      out  out_valid / out_stall pnm_pkg::pnm_out_t (one result per transfer)
//
// One byte per cycle unless out_stall holds a result or a P4 byte drains; header,
// P5 and P6 bytes give at most one result each. A P4 byte gives up to eight pixels
// via the single output register; input is stalled while its bits drain. Input
// register, then result register. Reset is synchronous and clears the control
// and parser state; no clearing pass. While a result is stalled, bytes that give
// no result keep moving; the next byte that gives one waits.
`default_nettype none

module pnm_binary_image_decoder #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pnm_pkg::pnm_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pnm_pkg::pnm_out_t      out_data
);

  `include "assert_macros.svh"

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam logic [15:0] MAX_W16 = 16'(MAX_WIDTH);
  localparam logic [15:0] MAX_H16 = 16'(MAX_HEIGHT);

  typedef enum logic [2:0] {
    PH_MAGIC, PH_TYPE, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PIXELS, PH_DONE, PH_ERROR
  } phase_t;

  // input register
  logic             in_vld_r;
  pnm_pkg::pnm_in_t in_q_r;

  // parser state
  phase_t                    phase_r, phase_nxt;
  logic [pnm_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      in_number_r, in_number_nxt;
  logic                      in_comment_r, in_comment_nxt;
  logic [1:0]                kind_r, kind_nxt;
  logic [WW-1:0]             width_r, width_nxt;
  logic [HW-1:0]             height_r, height_nxt;
  logic [WW-1:0]             col_r, col_nxt;
  logic [HW-1:0]             row_r, row_nxt;
  logic [1:0]                color_r, color_nxt;
  logic [7:0]                red_r, red_nxt;
  logic [7:0]                green_r, green_nxt;
  logic [2:0]                bit_idx_r, bit_idx_nxt;

  // output register
  logic              out_valid_r;
  pnm_pkg::pnm_out_t out_data_r;

  phase_t            cur_phase;
  logic [7:0]        c;
  logic              do_err, do_hdr, do_pix, num_done, byte_done, pix_last;
  logic [2:0]        err_code;
  logic [7:0]        gray, red, green, blue;
  logic [19:0]       acc_mac;
  logic              row_wrap, img_fin;
  logic              emit_req, out_free, fire, consume;
  logic [15:0]       w16, h16, x16, y16;
  pnm_pkg::pnm_out_t res;

  assign c         = in_q_r.data_byte;
  assign cur_phase = in_q_r.new_file ? PH_MAGIC : phase_r;
  assign acc_mac   = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {16'b0, c[3:0]};
  assign row_wrap  = ({1'b0, col_r} + 1'b1) >= {1'b0, width_r};
  assign img_fin   = row_wrap && (({1'b0, row_r} + 1'b1) >= {1'b0, height_r});

  always_comb begin
    phase_nxt      = cur_phase;
    acc_nxt        = acc_r;
    ovf_nxt        = ovf_r;
    in_number_nxt  = in_number_r;
    in_comment_nxt = in_comment_r;
    kind_nxt       = kind_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    color_nxt      = color_r;
    red_nxt        = red_r;
    green_nxt      = green_r;
    bit_idx_nxt    = bit_idx_r;
    do_err         = 1'b0;
    do_hdr         = 1'b0;
    do_pix         = 1'b0;
    num_done       = 1'b0;
    byte_done      = 1'b1;
    pix_last       = 1'b0;
    err_code       = pnm_pkg::ERR_NONE;
    gray           = 8'd0;
    red            = 8'd0;
    green          = 8'd0;
    blue           = 8'd0;

    case (cur_phase)
      PH_MAGIC: begin
        if (c != pnm_pkg::CH_P) begin
          do_err   = 1'b1;
          err_code = pnm_pkg::ERR_NOT_P;
        end else begin
          phase_nxt = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (c >= pnm_pkg::CH_4 && c <= pnm_pkg::CH_6) begin
          kind_nxt       = 2'(c - pnm_pkg::CH_4);
          acc_nxt        = '0;
          ovf_nxt        = 1'b0;
          in_number_nxt  = 1'b0;
          in_comment_nxt = 1'b0;
          phase_nxt      = PH_WIDTH;
        end else if (c >= pnm_pkg::CH_1 && c <= pnm_pkg::CH_3) begin
          do_err   = 1'b1;
          err_code = pnm_pkg::ERR_ASCII;
        end else begin
          do_err   = 1'b1;
          err_code = pnm_pkg::ERR_UNKNOWN;
        end
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
        if (in_comment_r) begin
          if (c == pnm_pkg::CH_LF || c == pnm_pkg::CH_CR) in_comment_nxt = 1'b0;
        end else if (c == pnm_pkg::CH_TAB || c == pnm_pkg::CH_LF ||
                     c == pnm_pkg::CH_CR || c == pnm_pkg::CH_SP) begin
          num_done = in_number_r;
        end else if (c == pnm_pkg::CH_HASH) begin
          in_comment_nxt = 1'b1;
        end else if (c >= pnm_pkg::CH_0 && c <= pnm_pkg::CH_9) begin
          if (ovf_r || acc_mac > pnm_pkg::ACC_CAP) begin
            ovf_nxt = 1'b1;
            acc_nxt = pnm_pkg::ACC_CAP[15:0];
          end else begin
            acc_nxt = acc_mac[15:0];
          end
          in_number_nxt = 1'b1;
        end else begin
          do_err   = 1'b1;
          err_code = pnm_pkg::ERR_HEADER;
        end

        if (num_done) begin
          acc_nxt       = '0;
          ovf_nxt       = 1'b0;
          in_number_nxt = 1'b0;
          case (cur_phase)
            PH_WIDTH: begin
              if (ovf_r || acc_r > MAX_W16) begin
                do_err   = 1'b1;
                err_code = pnm_pkg::ERR_SIZE;
              end else begin
                width_nxt = acc_r[WW-1:0];
                phase_nxt = PH_HEIGHT;
              end
            end
            PH_HEIGHT: begin
              if (ovf_r || acc_r > MAX_H16) begin
                do_err   = 1'b1;
                err_code = pnm_pkg::ERR_SIZE;
              end else begin
                height_nxt = acc_r[HW-1:0];
                if (kind_r == pnm_pkg::IMG_P4) do_hdr = 1'b1;
                else phase_nxt = PH_MAXVAL;
              end
            end
            default: begin
              if (ovf_r || acc_r > pnm_pkg::MAXVAL_LIMIT) begin
                do_err   = 1'b1;
                err_code = pnm_pkg::ERR_HEADER;
              end else begin
                do_hdr = 1'b1;
              end
            end
          endcase
        end

        if (do_hdr) begin
          col_nxt   = '0;
          row_nxt   = '0;
          color_nxt = 2'd0;
          phase_nxt = (width_nxt == '0 || height_nxt == '0) ? PH_DONE : PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        case (kind_r)
          pnm_pkg::IMG_P4: begin
            do_pix      = 1'b1;
            gray        = {7'd0, ~c[3'd7 - bit_idx_r]};
            byte_done   = row_wrap || (bit_idx_r == 3'd7);
            bit_idx_nxt = byte_done ? 3'd0 : bit_idx_r + 3'd1;
          end
          pnm_pkg::IMG_P5: begin
            do_pix = 1'b1;
            gray   = c;
          end
          pnm_pkg::IMG_P6: begin
            case (color_r)
              2'd0: begin
                red_nxt   = c;
                color_nxt = 2'd1;
              end
              2'd1: begin
                green_nxt = c;
                color_nxt = 2'd2;
              end
              default: begin
                do_pix    = 1'b1;
                red       = red_r;
                green     = green_r;
                blue      = c;
                color_nxt = 2'd0;
              end
            endcase
          end
          default: ;
        endcase

        if (do_pix) begin
          pix_last = img_fin;
          if (row_wrap) begin
            col_nxt = '0;
            row_nxt = row_r + 1'b1;
            if (img_fin) phase_nxt = PH_DONE;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (do_err) phase_nxt = PH_ERROR;
  end

  assign w16 = 16'(width_nxt);
  assign h16 = 16'(height_nxt);
  assign x16 = 16'(col_r);
  assign y16 = 16'(row_r);

  always_comb begin
    res = '0;
    if (do_err) begin
      res.kind       = pnm_pkg::KIND_ERR;
      res.error_code = err_code;
    end else begin
      res.kind       = do_hdr ? pnm_pkg::KIND_HDR : pnm_pkg::KIND_PIX;
      res.image_type = kind_nxt;
      res.img_width  = w16[12:0];
      res.img_height = h16[12:0];
      if (do_pix) begin
        res.pixel_x     = x16[11:0];
        res.pixel_y     = y16[11:0];
        res.gray_value  = gray;
        res.red_value   = red;
        res.green_value = green;
        res.blue_value  = blue;
        res.last        = pix_last;
      end
    end
  end

  assign emit_req = do_err || do_hdr || do_pix;
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = in_vld_r && (!emit_req || out_free);
  assign consume  = fire && byte_done;
  assign in_stall = in_vld_r && !consume;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= PH_MAGIC;
      acc_r        <= '0;
      ovf_r        <= 1'b0;
      in_number_r  <= 1'b0;
      in_comment_r <= 1'b0;
      kind_r       <= pnm_pkg::IMG_P4;
      width_r      <= '0;
      height_r     <= '0;
      col_r        <= '0;
      row_r        <= '0;
      color_r      <= 2'd0;
      red_r        <= 8'd0;
      green_r      <= 8'd0;
      bit_idx_r    <= 3'd0;
    end else begin
      if (in_valid && !in_stall) begin
        in_vld_r <= 1'b1;
        in_q_r   <= in_data;
      end else if (consume) begin
        in_vld_r <= 1'b0;
      end

      if (out_free) begin
        out_valid_r <= fire && emit_req;
      end
      if (fire && emit_req) begin
        out_data_r <= res;
      end

      if (fire) begin
        phase_r      <= phase_nxt;
        acc_r        <= acc_nxt;
        ovf_r        <= ovf_nxt;
        in_number_r  <= in_number_nxt;
        in_comment_r <= in_comment_nxt;
        kind_r       <= kind_nxt;
        width_r      <= width_nxt;
        height_r     <= height_nxt;
        col_r        <= col_nxt;
        row_r        <= row_nxt;
        color_r      <= color_nxt;
        red_r        <= red_nxt;
        green_r      <= green_nxt;
        bit_idx_r    <= bit_idx_nxt;
      end
    end
  end

  // a P4 bit walk only runs while pixels are being emitted
  `PNM_ASSERT_IMPLY(a_bit_walk_p4, bit_idx_r != 3'd0,
                    phase_r == PH_PIXELS && kind_r == pnm_pkg::IMG_P4)
  // the byte being unpacked stays in the input register until its last bit
  `PNM_ASSERT_NEXT(a_p4_byte_held, fire && !byte_done, in_vld_r)
  // error transfers always carry a code
  `PNM_ASSERT_IMPLY(a_err_has_code, out_valid && out_data.kind == pnm_pkg::KIND_ERR,
                    out_data.error_code != pnm_pkg::ERR_NONE)

endmodule

`default_nettype wire
